/* design/mfek_pkg.sv */
// shared types and constants of the maximum flow block
package mfek_pkg;

    localparam int VERTEX_COUNT_DEF  = 16;
    localparam int CAPACITY_BITS_DEF = 16;

    localparam int VERTEX_FIELD_BITS = 4;
    localparam int CAP_FIELD_BITS    = 16;
    localparam int FLOW_BITS         = 20;
    localparam int REG_INDEX_BITS    = 2;
    localparam int REG_DATA_BITS     = 4;

    localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;

    localparam logic [REG_INDEX_BITS-1:0] REG_SOURCE = 2'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_SINK   = 2'd1;

    localparam logic [VERTEX_FIELD_BITS-1:0] SOURCE_RESET = 4'd0;
    localparam logic [VERTEX_FIELD_BITS-1:0] SINK_RESET   = 4'd1;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_BFS_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MIN_P,
        ST_MIN_PW,
        ST_MIN_R,
        ST_UPD_P,
        ST_UPD_PW,
        ST_UPD_F,
        ST_UPD_B,
        ST_DONE
    } state_t;

endpackage

/* design/mfek_if.sv */
// handshake channels for input words and result words
interface mfek_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic [mfek_pkg::VERTEX_FIELD_BITS-1:0] from_vertex;
    logic [mfek_pkg::VERTEX_FIELD_BITS-1:0] to_vertex;
    logic [mfek_pkg::CAP_FIELD_BITS-1:0]    capacity;

    modport source (output valid, kind, from_vertex, to_vertex, capacity, input ready);
    modport sink (input valid, kind, from_vertex, to_vertex, capacity, output ready);
endinterface

interface mfek_out_if;
    logic                           valid;
    logic                           ready;
    logic [mfek_pkg::FLOW_BITS-1:0] flow_value;

    modport source (output valid, flow_value, input ready);
    modport sink (input valid, flow_value, output ready);
endinterface

/* design/max_flow_edmonds_karp.sv */
// maximum flow by breadth-first augmenting paths over a dense capacity matrix
//
//  channel  | dir | payload                                 | accepted when
//  ---------+-----+-----------------------------------------+------------------------------
//  item     | in  | kind, from_vertex, to_vertex, capacity  | item.valid & item.ready
//  result   | out | flow_value                              | result.valid & result.ready
//  config   | in  | reg_index, write_data                   | write_enable
//
//  a load word with in-range vertices writes one capacity entry while idle; a compute word
//  first copies the capacities into the residual memory, then runs searches until one finds
//  no path, takes the minimum residual along each path found and updates the residuals,
//  and then posts the result word (at once, with flow zero, if source and sink are not a valid pair)
//  after reset a clearing pass zeroes the capacity memory
//  a waiting result word does not block input; a finished compute waits for it
module max_flow_edmonds_karp #(
    parameter int VERTEX_COUNT  = mfek_pkg::VERTEX_COUNT_DEF,
    parameter int CAPACITY_BITS = mfek_pkg::CAPACITY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_enable,
    input  logic [mfek_pkg::REG_INDEX_BITS-1:0] reg_index,
    input  logic [mfek_pkg::REG_DATA_BITS-1:0]  write_data,
    mfek_in_if.sink                             item,
    mfek_out_if.source                          result
);
    import mfek_pkg::*;

    localparam int VB        = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int AW        = 2 * VB;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int Q_DEPTH   = 1 << VB;
    localparam int RB        = CAPACITY_BITS + 1;
    localparam int SUMW      = ((RB > FLOW_BITS) ? RB : FLOW_BITS) + 1;

    state_t state_reg, state_next;

    logic [VERTEX_FIELD_BITS-1:0] src_reg, src_next;
    logic [VERTEX_FIELD_BITS-1:0] dst_reg, dst_next;
    logic [AW:0]                  cnt_reg, cnt_next;
    logic [VB-1:0]                u_reg, u_next;
    logic [VB-1:0]                v_reg, v_next;
    logic [VB:0]                  head_reg, head_next;
    logic [VB:0]                  tail_reg, tail_next;
    logic [VERTEX_COUNT-1:0]      visited_reg, visited_next;
    logic [RB-1:0]                push_reg, push_next;
    logic [FLOW_BITS-1:0]         total_reg, total_next;
    logic                         out_valid_reg, out_valid_next;
    logic [FLOW_BITS-1:0]         flow_value_reg, flow_value_next;

    logic [CAPACITY_BITS-1:0] cap_mem [0:MEM_DEPTH-1];
    logic [RB-1:0]            res_mem [0:MEM_DEPTH-1];
    logic [VB-1:0]            q_mem   [0:Q_DEPTH-1];
    logic [VB-1:0]            par_mem [0:Q_DEPTH-1];

    logic [CAPACITY_BITS-1:0] cap_rd_reg;
    logic [RB-1:0]            res_rd_reg;
    logic [VB-1:0]            q_rd_reg;
    logic [VB-1:0]            par_rd_reg;

    logic                     cap_we;
    logic [AW-1:0]            cap_waddr;
    logic [CAPACITY_BITS-1:0] cap_wdata;
    logic                     res_we;
    logic [AW-1:0]            res_waddr;
    logic [RB-1:0]            res_wdata;
    logic [AW-1:0]            res_raddr;
    logic                     q_we;
    logic [VB-1:0]            q_waddr;
    logic [VB-1:0]            q_wdata;
    logic                     par_we;

    logic                                  accept;
    logic [CAPACITY_BITS+CAP_FIELD_BITS-1:0] cap_wide;
    logic [VB+VERTEX_FIELD_BITS-1:0]       from_wide, to_wide, src_wide, dst_wide;
    logic [VB-1:0]                         from_idx, to_idx, src_idx, dst_idx;
    logic                                  load_ok, pair_ok;
    logic                                  hit;
    logic [RB-1:0]                         push_min;
    logic [SUMW-1:0]                       sum_w;

    assign accept    = item.valid && item.ready;
    assign cap_wide  = (CAPACITY_BITS + CAP_FIELD_BITS)'(item.capacity);
    assign from_wide = (VB + VERTEX_FIELD_BITS)'(item.from_vertex);
    assign to_wide   = (VB + VERTEX_FIELD_BITS)'(item.to_vertex);
    assign src_wide  = (VB + VERTEX_FIELD_BITS)'(src_reg);
    assign dst_wide  = (VB + VERTEX_FIELD_BITS)'(dst_reg);
    assign from_idx  = from_wide[VB-1:0];
    assign to_idx    = to_wide[VB-1:0];
    assign src_idx   = src_wide[VB-1:0];
    assign dst_idx   = dst_wide[VB-1:0];
    assign load_ok   = (32'(item.from_vertex) < 32'(VERTEX_COUNT))
                    && (32'(item.to_vertex) < 32'(VERTEX_COUNT));
    assign pair_ok   = (32'(src_reg) < 32'(VERTEX_COUNT))
                    && (32'(dst_reg) < 32'(VERTEX_COUNT)) && (src_reg != dst_reg);
    assign hit       = !visited_reg[v_reg] && (res_rd_reg != '0);
    assign push_min  = (res_rd_reg < push_reg) ? res_rd_reg : push_reg;
    assign sum_w     = SUMW'(total_reg) + SUMW'(push_min);

    assign item.ready        = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.flow_value = flow_value_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == (AW + 1)'(MEM_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept && item.kind == KIND_COMPUTE)
                    state_next = pair_ok ? ST_COPY : ST_DONE;
            end
            ST_COPY:
            begin
                if (cnt_reg == (AW + 1)'(MEM_DEPTH))
                    state_next = ST_BFS_INIT;
            end
            ST_BFS_INIT: state_next = ST_POP;
            ST_POP:      state_next = (head_reg == tail_reg) ? ST_DONE : ST_POP_WAIT;
            ST_POP_WAIT: state_next = ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (hit && v_reg == dst_idx)
                    state_next = ST_MIN_P;
                else if (v_reg == VB'(VERTEX_COUNT - 1))
                    state_next = ST_POP;
                else
                    state_next = ST_SCAN_RD;
            end
            ST_MIN_P:    state_next = ST_MIN_PW;
            ST_MIN_PW:   state_next = ST_MIN_R;
            ST_MIN_R:    state_next = (u_reg == src_idx) ? ST_UPD_P : ST_MIN_P;
            ST_UPD_P:    state_next = ST_UPD_PW;
            ST_UPD_PW:   state_next = ST_UPD_F;
            ST_UPD_F:    state_next = ST_UPD_B;
            ST_UPD_B:    state_next = (u_reg == src_idx) ? ST_BFS_INIT : ST_UPD_P;
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        src_next        = src_reg;
        dst_next        = dst_reg;
        cnt_next        = cnt_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        visited_next    = visited_reg;
        push_next       = push_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        flow_value_next = flow_value_reg;
        cap_we          = 1'b0;
        cap_waddr       = cnt_reg[AW-1:0];
        cap_wdata       = '0;
        res_we          = 1'b0;
        res_waddr       = {u_reg, v_reg};
        res_wdata       = '0;
        res_raddr       = {u_reg, v_reg};
        q_we            = 1'b0;
        q_waddr         = tail_reg[VB-1:0];
        q_wdata         = v_reg;
        par_we          = 1'b0;

        if (write_enable)
        begin
            if (reg_index == REG_SOURCE)
                src_next = write_data;
            else if (reg_index == REG_SINK)
                dst_next = write_data;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                cap_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && item.kind == KIND_LOAD && load_ok)
                begin
                    cap_we    = 1'b1;
                    cap_waddr = {from_idx, to_idx};
                    cap_wdata = cap_wide[CAPACITY_BITS-1:0];
                end
                if (accept && item.kind == KIND_COMPUTE)
                    total_next = '0;
            end
            ST_COPY:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    res_we    = 1'b1;
                    res_waddr = AW'(cnt_reg - 1'b1);
                    res_wdata = RB'(cap_rd_reg);
                end
            end
            ST_BFS_INIT:
            begin
                visited_next          = '0;
                visited_next[src_idx] = 1'b1;
                q_we                  = 1'b1;
                q_waddr               = '0;
                q_wdata               = src_idx;
                head_next             = '0;
                tail_next             = (VB + 1)'(1);
            end
            ST_POP_WAIT:
            begin
                u_next    = q_rd_reg;
                v_next    = '0;
                head_next = head_reg + 1'b1;
            end
            ST_SCAN_CHK:
            begin
                if (hit)
                begin
                    visited_next[v_reg] = 1'b1;
                    par_we              = 1'b1;
                    if (tail_reg < (VB + 1)'(VERTEX_COUNT))
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (hit && v_reg == dst_idx)
                    push_next = '1;
                else if (v_reg != VB'(VERTEX_COUNT - 1))
                    v_next = v_reg + 1'b1;
            end
            ST_MIN_PW, ST_UPD_PW:
            begin
                u_next    = par_rd_reg;
                res_raddr = {par_rd_reg, v_reg};
            end
            ST_MIN_R:
            begin
                push_next = push_min;
                v_next    = u_reg;
                if (u_reg == src_idx)
                begin
                    v_next     = dst_idx;
                    total_next = (sum_w > SUMW'(FLOW_MAX)) ? FLOW_MAX : sum_w[FLOW_BITS-1:0];
                end
            end
            ST_UPD_F:
            begin
                res_we    = 1'b1;
                res_waddr = {u_reg, v_reg};
                res_wdata = res_rd_reg - push_reg;
                res_raddr = {v_reg, u_reg};
            end
            ST_UPD_B:
            begin
                res_we    = 1'b1;
                res_waddr = {v_reg, u_reg};
                res_wdata = res_rd_reg + push_reg;
                v_next    = u_reg;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    flow_value_next = total_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            src_reg       <= SOURCE_RESET;
            dst_reg       <= SINK_RESET;
            cnt_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            visited_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            visited_reg   <= visited_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg          <= u_next;
        v_reg          <= v_next;
        push_reg       <= push_next;
        flow_value_reg <= flow_value_next;
    end

    // capacity store
    always_ff @(posedge clk)
    begin
        if (cap_we)
            cap_mem[cap_waddr] <= cap_wdata;
        cap_rd_reg <= cap_mem[cnt_reg[AW-1:0]];
    end

    // residual store
    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_waddr] <= res_wdata;
        res_rd_reg <= res_mem[res_raddr];
    end

    // search queue and parent links
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr] <= q_wdata;
        if (par_we)
            par_mem[v_reg] <= u_reg;
        q_rd_reg   <= q_mem[head_reg[VB-1:0]];
        par_rd_reg <= par_mem[v_reg];
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside completion");

    a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD_F |-> push_reg != '0)
        else $error("augmenting with zero push");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD_F |-> res_rd_reg >= push_reg)
        else $error("push exceeds forward residual");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= (VB + 1)'(VERTEX_COUNT) && head_reg <= tail_reg)
        else $error("search queue pointers out of order");

    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY |=> !item.ready || state_reg == ST_IDLE)
        else $error("input taken during compute");

endmodule
